[rtl/mpkt_pkg.sv]
// Shared widths, limits and the item record that moves between cells of the chain.
package mpkt_pkg;

	localparam int PRICE_W  = 16;
	localparam int PROFIT_W = 31;
	localparam int HOLD_W   = 33;
	localparam int CFG_W    = 7;

	// Largest profit a not-holding level may record.
	localparam logic [PROFIT_W-1:0] PROFIT_TOP = {PROFIT_W{1'b1}};

	// One item on its way down the chain, with the not-holding value of the level above
	// and the result picked up so far.
	typedef struct packed {
		logic                valid;
		logic                first;
		logic [PRICE_W-1:0]  price;
		logic [PROFIT_W-1:0] nh;
		logic [PROFIT_W-1:0] res;
	} stage_t;

endpackage

[rtl/mpkt_cell.sv]
// One transaction level of the chain: holds its two row entries and passes the item on.
module mpkt_cell #(
	parameter int LEVEL = 1,
	parameter int KW    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [KW-1:0]    k,
	input  mpkt_pkg::stage_t up,
	output mpkt_pkg::stage_t down
);
	import mpkt_pkg::*;

	logic signed [HOLD_W-1:0] hold_q;
	logic signed [HOLD_W-1:0] hold_nx;
	logic signed [HOLD_W-1:0] price_x;
	logic signed [HOLD_W-1:0] buy;
	logic signed [HOLD_W-1:0] sold;
	logic [PROFIT_W-1:0]      sold_sat;
	logic [PROFIT_W-1:0]      nh_q;
	logic [PROFIT_W-1:0]      nh_nx;
	stage_t                   stage_s1;

	always_comb begin
		price_x = $signed({{(HOLD_W-PRICE_W){1'b0}}, up.price});
		buy     = $signed({{(HOLD_W-PROFIT_W){1'b0}}, up.nh}) - price_x;
		if (up.first) begin
			hold_nx = -price_x;
		end else if (buy > hold_q) begin
			hold_nx = buy;
		end else begin
			hold_nx = hold_q;
		end
		// Selling never goes negative here, so only the top needs clamping.
		sold = hold_nx + price_x;
		if (sold > $signed({{(HOLD_W-PROFIT_W){1'b0}}, PROFIT_TOP})) begin
			sold_sat = PROFIT_TOP;
		end else begin
			sold_sat = sold[PROFIT_W-1:0];
		end
		if (up.first) begin
			nh_nx = '0;
		end else if (sold_sat > nh_q) begin
			nh_nx = sold_sat;
		end else begin
			nh_nx = nh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			nh_q   <= '0;
		end else if (adv && up.valid) begin
			hold_q <= hold_nx;
			nh_q   <= nh_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (adv) begin
			stage_s1.valid <= up.valid;
			stage_s1.first <= up.first;
			stage_s1.price <= up.price;
			stage_s1.nh    <= nh_nx;
			stage_s1.res   <= (k == KW'(LEVEL)) ? nh_nx : up.res;
		end
	end

	assign down = stage_s1;

endmodule

[rtl/max_profit_k_trades.sv]
// Top level: a chain of transaction-level cells that tracks the best k-trade profit.
// A new price item can enter in every cycle in which in_stall is low. Each item walks down
// a chain of MAX_TRADES cells, one cell per cycle while the chain advances, and then
// through the output register. The first cell loads the item at the edge that accepts it.
// The sustained rate is one item per cycle when out_stall stays low. Cell i keeps the best
// cash while holding stock for transaction i and the best cash with at most i completed
// transactions; it updates both from the price and the not-holding value that cell i-1
// registered for the same item. The result is picked up as the item passes the cell whose
// level equals max_trades (clamped to MAX_TRADES; a limit of zero yields zero). The whole
// chain moves together and halts while the output register holds an item that is stalled,
// so in_stall follows out_stall in the same cycle. max_trades must only be written while
// no item is in flight.
module max_profit_k_trades #(
	parameter int MAX_TRADES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          max_trades_wr_en,
	input  logic [mpkt_pkg::CFG_W-1:0]    max_trades,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mpkt_pkg::PRICE_W-1:0]  price,
	input  logic                          first_of_series,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mpkt_pkg::PROFIT_W-1:0] best_profit
);
	import mpkt_pkg::*;

	localparam int LW = $clog2(MAX_TRADES + 1);
	localparam int KW = (LW > CFG_W) ? LW : CFG_W;

	logic [CFG_W-1:0]    max_trades_q;
	logic [KW-1:0]       k_ext;
	logic [KW-1:0]       k;
	logic                adv;
	logic                out_valid_q;
	logic [PROFIT_W-1:0] res_q;
	logic [MAX_TRADES:1] stage_vld;
	stage_t              chain [0:MAX_TRADES];

	// The trade limit register; resets to one transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trades_q <= CFG_W'(1);
		end else if (max_trades_wr_en) begin
			max_trades_q <= max_trades;
		end
	end

	// Limits above the chain length select the last level.
	always_comb begin
		k_ext = KW'(max_trades_q);
		if (k_ext > KW'(MAX_TRADES)) begin
			k = KW'(MAX_TRADES);
		end else begin
			k = k_ext;
		end
	end

	// The chain advances unless a finished item sits stalled in the output register.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Level zero never trades, so its not-holding value and a zero limit's result are 0.
	assign chain[0] = '{valid: in_valid, first: first_of_series, price: price,
		nh: '0, res: '0};

	for (genvar i = 1; i <= MAX_TRADES; i++) begin : g_cell
		mpkt_cell #(
			.LEVEL (i),
			.KW    (KW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.k      (k),
			.up     (chain[i-1]),
			.down   (chain[i])
		);
		assign stage_vld[i] = chain[i].valid;
	end

	// Output register at the end of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[MAX_TRADES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= chain[MAX_TRADES].res;
		end
	end

	assign out_valid   = out_valid_q;
	assign best_profit = res_q;

	// A stalled result freezes every stage of the chain.
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(stage_vld))
		else $error("chain moved while the output was stalled");

	// A result only appears when an item left the last cell.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(stage_vld[MAX_TRADES]))
		else $error("result appeared without an item leaving the chain");

	// An empty chain with an empty output register produces nothing next cycle.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && (stage_vld == '0)) |=> !out_valid_q)
		else $error("result appeared from an empty chain");

endmodule

[bench/tb_max_profit_k_trades.sv]
// Self-checking testbench for the k-transaction best-profit chain, with its own profit predictor.
module tb_max_profit_k_trades;
	import mpkt_pkg::*;

	// Chain depth of the block under test. The result of an item passes every cell and
	// the output register on its way out of the block.
	localparam int LEVELS = 64;
	// Cycles without any accepted item or result before the run is declared hung.
	// The slowest correct run sees the chain latency plus a long receiver stall
	// between two accepted events, far below this.
	localparam int HANG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int PHASES = 8;
	localparam int REPORT_LIMIT = 10;

	// How the prices of one random series are shaped.
	typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_WALK, STYLE_ZIGZAG} price_style_e;
	// Receiver back-pressure patterns.
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	// Tracks the two rows of the dynamic program for every transaction level and keeps
	// the best profits that the block still owes, oldest first.
	class profit_scoreboard;
		longint                 cash_free[0:LEVELS];
		longint                 cash_held[0:LEVELS-1];
		logic [CFG_W-1:0]       trade_limit;
		logic [PROFIT_W-1:0]    owed_profits[$];
		int                     failures;
		int                     prices_seen;
		int                     profits_seen;
		int                     series_seen;
		int                     limits_written;

		function new();
			foreach (cash_free[i]) cash_free[i] = 0;
			foreach (cash_held[i]) cash_held[i] = 0;
			trade_limit = CFG_W'(1);
		endfunction

		function void set_limit(logic [CFG_W-1:0] limit);
			trade_limit = limit;
			limits_written++;
		endfunction

		function void report(string what, logic [PROFIT_W-1:0] want, logic [PROFIT_W-1:0] got);
			failures++;
			if (failures <= REPORT_LIMIT) begin
				$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
			end
		endfunction

		// One accepted price: update every level and queue the profit at the chosen level.
		function void note_price(logic [PRICE_W-1:0] price, logic opens);
			longint pv;
			longint sold;
			int k;
			pv = longint'(price);
			k = (trade_limit > LEVELS) ? LEVELS : int'(trade_limit);
			prices_seen++;
			if (opens) begin
				series_seen++;
				foreach (cash_free[i]) cash_free[i] = 0;
				foreach (cash_held[i]) cash_held[i] = -pv;
			end else begin
				for (int i = 1; i <= LEVELS; i++) begin
					if (cash_free[i-1] - pv > cash_held[i-1]) begin
						cash_held[i-1] = cash_free[i-1] - pv;
					end
					sold = cash_held[i-1] + pv;
					if (sold > longint'(PROFIT_TOP)) begin
						sold = longint'(PROFIT_TOP);
					end
					if (sold > cash_free[i]) begin
						cash_free[i] = sold;
					end
				end
			end
			owed_profits.push_back(cash_free[k][PROFIT_W-1:0]);
		endfunction

		// One accepted result: compare with the oldest owed profit.
		function void check_profit(logic [PROFIT_W-1:0] got);
			logic [PROFIT_W-1:0] want;
			profits_seen++;
			if (owed_profits.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = owed_profits.pop_front();
				if (want !== got) begin
					report("best_profit", want, got);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                max_trades_wr_en = 1'b0;
	logic [CFG_W-1:0]    max_trades = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [PRICE_W-1:0]  price = '0;
	logic                first_of_series = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PROFIT_W-1:0] best_profit;

	profit_scoreboard sb = new();

	// Sender burst state: items left in the current burst.
	int burst_left = 0;
	// Receiver pattern state.
	stall_mode_e stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;
	// Watchdog state.
	int quiet_cycles = 0;
	logic progress;

	max_profit_k_trades #(
		.MAX_TRADES(LEVELS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_trades_wr_en (max_trades_wr_en),
		.max_trades       (max_trades),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.price            (price),
		.first_of_series  (first_of_series),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.best_profit      (best_profit)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// All handshakes are observed here, at the rising edge, in one process: a result is
	// checked before the item accepted at the same edge is predicted, so the outcome never
	// hangs on the order in which processes wake up. The watchdog lives here as well.
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (out_valid && !out_stall) begin
				sb.check_profit(best_profit);
				progress = 1'b1;
			end
			if (in_valid && !in_stall) begin
				sb.note_price(price, first_of_series);
				progress = 1'b1;
			end
			quiet_cycles = progress ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// The receiver switches between four back-pressure patterns at random, so stalls
	// land on every phase of the chain, including long stretches with no stall at all.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: begin
				out_stall = 1'b0;
			end
			STALL_LIGHT: begin
				out_stall = ($urandom_range(0, 99) < 25);
			end
			STALL_PERIODIC: begin
				out_stall = ((stall_tick % 7) < 3);
			end
			default: begin
				out_stall = ($urandom_range(0, 99) < 70);
			end
		endcase
	end

	// Offers one item at the current falling edge and returns at the falling edge after it
	// was accepted. Bursts of random length are separated by random gaps; a gap of zero
	// keeps the valid high from one burst into the next.
	task automatic push_price(input logic [PRICE_W-1:0] p, input logic opens);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid = 1'b1;
		price = p;
		first_of_series = opens;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until the block has delivered every owed result. Every item
	// yields a result, so at that point nothing is left in the chain.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.owed_profits.size() != 0) @(negedge clk);
	endtask

	// Writes the trade limit; only called after drain().
	task automatic write_limit(input logic [CFG_W-1:0] limit);
		max_trades_wr_en = 1'b1;
		max_trades = limit;
		sb.set_limit(limit);
		@(negedge clk);
		max_trades_wr_en = 1'b0;
	endtask

	initial begin
		int limits[PHASES];
		int sent;
		int len;
		int step;
		logic continues;
		logic opens;
		price_style_e style;
		logic [PRICE_W-1:0] p;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Right after reset the limit is one and no series has been opened:
		// these prices act on the all-zero rows just as later prices would.
		push_price(16'd100, 1'b0);
		push_price(16'd50, 1'b0);
		push_price(16'd300, 1'b0);
		// One trade over full-swing prices.
		push_price(16'hFFFF, 1'b1);
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);
		// A limit of zero must always report zero profit.
		drain();
		write_limit(7'd0);
		push_price(16'd10, 1'b1);
		push_price(16'd500, 1'b0);
		push_price(16'd20, 1'b0);
		// A limit above the chain depth behaves like the deepest level.
		drain();
		write_limit(7'd127);
		push_price(16'h0000, 1'b1);
		push_price(16'hFFFF, 1'b0);
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);
		// The deepest level itself, changed in the middle of the series above.
		drain();
		write_limit(7'(LEVELS));
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);
		push_price(16'hFFFF, 1'b1);
		push_price(16'h0000, 1'b0);
		push_price(16'hFFFF, 1'b0);

		// Random part: several phases, each with its own trade limit. Every odd phase keeps
		// going with the series left from the phase before, so a changed limit reads another
		// level of the same rows. Most items are well-formed series of shaped prices; short
		// series and stray series starts make up the noise.
		limits = '{2, LEVELS, 0, 127, 1, $urandom_range(3, LEVELS - 1),
			$urandom_range(LEVELS + 1, 126), $urandom_range(0, 127)};
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_limit(7'(limits[ph]));
			continues = ph[0];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
				style = price_style_e'($urandom_range(0, 3));
				p = 16'($urandom_range(0, 65535));
				for (int j = 0; j < len && sent < ITEMS_PER_PHASE; j++) begin
					opens = (j == 0 && !continues) || ($urandom_range(0, 49) == 0);
					push_price(p, opens);
					sent++;
					case (style)
						STYLE_UNIFORM: begin
							p = 16'($urandom_range(0, 65535));
						end
						STYLE_EXTREME: begin
							p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
						end
						STYLE_WALK: begin
							step = int'(p) + $urandom_range(0, 600) - 300;
							p = (step < 0) ? 16'h0000 : (step > 65535) ? 16'hFFFF : 16'(step);
						end
						default: begin
							p = p[PRICE_W-1] ? 16'($urandom_range(0, 32767))
								: 16'($urandom_range(32768, 65535));
						end
					endcase
				end
				continues = 1'b0;
			end
		end

		// Wait for the last results, then leave the chain time to show any extra ones.
		drain();
		repeat (LEVELS + 8) @(negedge clk);
		sb.failures += sb.owed_profits.size();

		$display("Covered %0d prices in %0d series and %0d results under %0d trade limits.",
			sb.prices_seen, sb.series_seen, sb.profits_seen, sb.limits_written);
		$display("Limits included zero, one, the chain depth and values above it.");
		if (sb.failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Mismatches: %0d", sb.failures);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/mpkt_pkg.sv
rtl/mpkt_cell.sv
rtl/max_profit_k_trades.sv
bench/tb_max_profit_k_trades.sv
